// File: sv/tmv_pkg.sv
`timescale 1ns / 1ps

package tmv_pkg;

  // fixed field widths
  localparam int WLEN_W     = 7;
  localparam int FS_W       = 23;
  localparam int CH_W       = 2;
  localparam int VOLT_W     = 23;
  localparam int SUM_OUT_W  = 18;
  localparam int KEPT_W     = 7;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd1;

  // register reset values
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 7'd50;
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 23'd3300000;

  // control for the sorting row
  typedef struct packed {
    logic insert;
    logic drain;
  } chain_ctl_t;

endpackage

// File: sv/tmv_cell.sv
`timescale 1ns / 1ps

module tmv_cell #(
  parameter int DW = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  tmv_pkg::chain_ctl_t ctl,
  input  logic [DW-1:0]      new_sample,
  input  logic [DW-1:0]      left_data,
  input  logic               left_valid,
  input  logic               left_gt,
  input  logic [DW-1:0]      right_data,
  input  logic               right_valid,
  output logic [DW-1:0]      data,
  output logic               valid,
  output logic               gt
);

  logic take;

  // stored value sits above the incoming sample
  assign gt   = valid && (data > new_sample);
  // shift right, or become the new tail slot
  assign take = gt || (!valid && left_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= right_valid;
    end else if (ctl.insert && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      data <= right_data;
    end else if (ctl.insert && take) begin
      data <= left_gt ? left_data : new_sample;
    end
  end

endmodule

// File: sv/tmv_chain.sv
`timescale 1ns / 1ps

module tmv_chain #(
  parameter int DEPTH = 64,
  parameter int DW    = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  tmv_pkg::chain_ctl_t ctl,
  input  logic [DW-1:0]       new_sample,
  output logic [DW-1:0]       head
);

  logic [DW-1:0] cdata  [DEPTH];
  logic          cvalid [DEPTH];
  logic          cgt    [DEPTH];

  // row of cells, smallest value at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] l_data;
    logic          l_valid;
    logic          l_gt;
    logic [DW-1:0] r_data;
    logic          r_valid;

    if (i == 0) begin : g_first
      assign l_data  = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_mid
      assign l_data  = cdata[i-1];
      assign l_valid = cvalid[i-1];
      assign l_gt    = cgt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cdata[i+1];
      assign r_valid = cvalid[i+1];
    end

    tmv_cell #(.DW(DW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_sample  (new_sample),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cdata[i]),
      .valid       (cvalid[i]),
      .gt          (cgt[i])
    );
  end

  assign head = cdata[0];

endmodule

// File: sv/tmv_muldiv.sv
`timescale 1ns / 1ps

module tmv_muldiv #(
  parameter int SW = 19,
  parameter int DW = 19
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [SW-1:0]            sum,
  input  logic [tmv_pkg::FS_W-1:0] scale,
  input  logic [DW-1:0]            den,
  output logic                     done,
  output logic [SW+tmv_pkg::FS_W-1:0] quotient
);

  localparam int PW = SW + tmv_pkg::FS_W;
  localparam int CNTW = $clog2(PW + 1);

  logic            busy;
  logic            is_div;
  logic [CNTW-1:0] step;
  logic [PW-1:0]   acc;
  logic [DW-1:0]   rem;
  logic [SW:0]     upper;
  logic [DW:0]     rem_sh;
  logic            q_bit;

  // shift-add multiply step: add sum into the top when the low bit is set
  assign upper  = {1'b0, acc[PW-1:tmv_pkg::FS_W]} + (acc[0] ? {1'b0, sum} : '0);
  // restoring divide step
  assign rem_sh = {rem, acc[PW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      is_div <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= !start && busy && is_div && (step == CNTW'(PW - 1));
      if (start) begin
        busy   <= 1'b1;
        is_div <= 1'b0;
        step   <= '0;
      end else if (busy) begin
        if (!is_div && step == CNTW'(tmv_pkg::FS_W - 1)) begin
          is_div <= 1'b1;
          step   <= '0;
        end else if (is_div && step == CNTW'(PW - 1)) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {{SW{1'b0}}, scale};
      rem <= '0;
    end else if (busy && !is_div) begin
      acc <= {upper, acc[tmv_pkg::FS_W-1:1]};
    end else if (busy) begin
      rem <= q_bit ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
      acc <= {acc[PW-2:0], q_bit};
    end
  end

  assign quotient = acc;

endmodule

// File: sv/adc_trimmed_mean_voltage.sv
`timescale 1ns / 1ps

// channel   handshake             payload
// input     in_valid / in_stall   sample, channel
// output    out_valid / out_stall channel_out, voltage_uv, trimmed_sum, kept_count
// config    cfg_write             cfg_index, cfg_data
//
// samples are taken one per cycle while in_stall is low; each goes straight into the
// sorting row of cells. the sample that completes a window starts the result pass: the
// row drains through cell 0, then the unit is started and runs the shift-add multiply
// and the restoring divide, and once its finish is seen the output register is loaded;
// in_stall is high for that pass.
// the result waits in the output register; a later window stalls only if its result
// is ready while the previous one has not been taken.
// reset (synchronous, rst) empties the window and restores the register defaults.

module adc_trimmed_mean_voltage #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [tmv_pkg::CH_W-1:0]       channel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tmv_pkg::CH_W-1:0]       channel_out,
  output logic [tmv_pkg::VOLT_W-1:0]     voltage_uv,
  output logic [tmv_pkg::SUM_OUT_W-1:0]  trimmed_sum,
  output logic [tmv_pkg::KEPT_W-1:0]     kept_count
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int NW = (CW > tmv_pkg::WLEN_W) ? CW : tmv_pkg::WLEN_W;
  localparam int SW = SAMPLE_BITS + CW;
  localparam int DW = SAMPLE_BITS + CW;
  localparam int PW = SW + tmv_pkg::FS_W;

  localparam logic [1:0] ST_IN    = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                   state;
  logic [tmv_pkg::WLEN_W-1:0]   window_len;
  logic [tmv_pkg::FS_W-1:0]     full_scale_uv;
  logic [CW-1:0]                cnt;
  logic [2:0]                   mod5;
  logic [CW-1:0]                trim;
  logic [CW-1:0]                n_win;
  logic [CW-1:0]                trim_win;
  logic [CW-1:0]                kept_win;
  logic [CW-1:0]                k;
  logic [SW-1:0]                acc;
  logic [tmv_pkg::CH_W-1:0]     ch_last;
  logic                         calc_start;
  logic                         calc_done;
  logic [PW-1:0]                quotient;
  logic [SAMPLE_BITS-1:0]       head;
  tmv_pkg::chain_ctl_t          ctl;

  logic                         accept;
  logic [CW-1:0]                cnt_inc;
  logic [CW-1:0]                trim_inc;
  logic [2:0]                   mod5_inc;
  logic [NW-1:0]                eff;
  logic                         win_done;
  logic                         keep_k;
  logic [DW-1:0]                den;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= tmv_pkg::WINDOW_LEN_RST;
      full_scale_uv <= tmv_pkg::FULL_SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tmv_pkg::REG_WINDOW_LEN: window_len    <= cfg_data[tmv_pkg::WLEN_W-1:0];
        tmv_pkg::REG_FULL_SCALE: full_scale_uv <= cfg_data[tmv_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IN);
  assign accept   = in_valid && !in_stall;

  // running count, its value mod 5 and the trim depth floor(count/5)
  assign cnt_inc  = cnt + 1'b1;
  assign mod5_inc = (mod5 == 3'd4) ? 3'd0 : mod5 + 3'd1;
  assign trim_inc = (mod5 == 3'd4) ? trim + 1'b1 : trim;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      eff = NW'(1);
    end else if (NW'(window_len) > NW'(MAX_WINDOW)) begin
      eff = NW'(MAX_WINDOW);
    end else begin
      eff = NW'(window_len);
    end
  end
  assign win_done = (NW'(cnt_inc) >= eff);

  // drain position lies between the trimmed ends
  assign keep_k = ((CW+1)'(k) >= (CW+1)'(trim_win)) &&
                  ((CW+1)'(k) < ((CW+1)'(trim_win) + (CW+1)'(kept_win)));

  assign ctl.insert = accept;
  assign ctl.drain  = (state == ST_DRAIN);

  tmv_chain #(.DEPTH(MAX_WINDOW), .DW(SAMPLE_BITS)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .new_sample (sample),
    .head       (head)
  );

  // kept * (2^SAMPLE_BITS - 1)
  assign den = DW'({kept_win, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, kept_win});

  tmv_muldiv #(.SW(SW), .DW(DW)) u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (calc_start),
    .sum      (acc),
    .scale    (full_scale_uv),
    .den      (den),
    .done     (calc_done),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IN;
      cnt        <= '0;
      mod5       <= '0;
      trim       <= '0;
      k          <= '0;
      calc_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      calc_start <= (state == ST_DRAIN) && (k == n_win - 1'b1);
      // result handed over, or a new one loaded
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IN: begin
          if (accept) begin
            if (win_done) begin
              cnt   <= '0;
              mod5  <= '0;
              trim  <= '0;
              k     <= '0;
              state <= ST_DRAIN;
            end else begin
              cnt  <= cnt_inc;
              mod5 <= mod5_inc;
              trim <= trim_inc;
            end
          end
        end
        ST_DRAIN: begin
          k <= k + 1'b1;
          if (k == n_win - 1'b1) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (calc_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IN;
          end
        end
        default: state <= ST_IN;
      endcase
    end
  end

  // window figures and the running sum
  always_ff @(posedge clk) begin
    if (accept && win_done) begin
      n_win    <= cnt_inc;
      trim_win <= trim_inc;
      kept_win <= CW'(cnt_inc - {trim_inc, 1'b0});
      ch_last  <= channel;
      acc      <= '0;
    end else if (state == ST_DRAIN && keep_k) begin
      acc <= acc + SW'(head);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      channel_out <= ch_last;
      voltage_uv  <= tmv_pkg::VOLT_W'(quotient);
      trimmed_sum <= tmv_pkg::SUM_OUT_W'(acc);
      kept_count  <= tmv_pkg::KEPT_W'(kept_win);
    end
  end

endmodule

// File: tb/tmv_reading_checker.sv
`timescale 1ns / 1ps

module tmv_reading_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [11:0]                    sample,
  input  logic [tmv_pkg::CH_W-1:0]       channel,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [tmv_pkg::CH_W-1:0]       channel_out,
  input  logic [tmv_pkg::VOLT_W-1:0]     voltage_uv,
  input  logic [tmv_pkg::SUM_OUT_W-1:0]  trimmed_sum,
  input  logic [tmv_pkg::KEPT_W-1:0]     kept_count,
  output int                             fail_count,
  output int                             readings_due
);

  localparam int WINDOW_DEPTH = 64;
  localparam longint unsigned TOP_CODE = 4095;

  typedef struct packed {
    logic [tmv_pkg::CH_W-1:0]      ch;
    logic [tmv_pkg::VOLT_W-1:0]    volt;
    logic [tmv_pkg::SUM_OUT_W-1:0] sum;
    logic [tmv_pkg::KEPT_W-1:0]    kept;
  } reading_t;

  // register mirror and sorted window copy
  logic [tmv_pkg::WLEN_W-1:0] window_len_reg = tmv_pkg::WINDOW_LEN_RST;
  logic [tmv_pkg::FS_W-1:0]   full_scale_reg = tmv_pkg::FULL_SCALE_RST;
  logic [11:0]                window_codes [WINDOW_DEPTH];
  int                         gathered = 0;
  reading_t                   expected_readings [$];
  int                         errors = 0;
  int                         shown = 0;

  initial begin
    fail_count   = 0;
    readings_due = 0;
  end

  // insert one code in ascending order and close the window when it is full
  function automatic void fold_sample(logic [11:0] code, logic [tmv_pkg::CH_W-1:0] ch);
    int pos;
    int span;
    int n;
    int trim;
    int kept;
    longint unsigned total;
    longint unsigned volts;
    reading_t r;
    if (gathered < WINDOW_DEPTH) begin
      pos = gathered;
      while (pos > 0 && window_codes[pos-1] > code) begin
        window_codes[pos] = window_codes[pos-1];
        pos--;
      end
      window_codes[pos] = code;
      gathered++;
    end
    span = (window_len_reg == 0) ? 1 :
           ((window_len_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(window_len_reg));
    if (gathered < span) return;
    n     = gathered;
    trim  = n / 5;
    kept  = n - 2 * trim;
    total = 0;
    for (int i = trim; i < n - trim; i++) total += window_codes[i];
    volts  = (total * full_scale_reg) / (longint'(kept) * TOP_CODE);
    r.ch   = ch;
    r.volt = volts[tmv_pkg::VOLT_W-1:0];
    r.sum  = total[tmv_pkg::SUM_OUT_W-1:0];
    r.kept = kept[tmv_pkg::KEPT_W-1:0];
    expected_readings.push_back(r);
    gathered = 0;
  endfunction

  // watch config, input and output channels
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (rst) begin
      window_len_reg = tmv_pkg::WINDOW_LEN_RST;
      full_scale_reg = tmv_pkg::FULL_SCALE_RST;
      gathered       = 0;
      expected_readings.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == tmv_pkg::REG_WINDOW_LEN)
          window_len_reg = cfg_data[tmv_pkg::WLEN_W-1:0];
        else if (cfg_index == tmv_pkg::REG_FULL_SCALE)
          full_scale_reg = cfg_data[tmv_pkg::FS_W-1:0];
      end
      if (in_valid && !in_stall) fold_sample(sample, channel);
      if (out_valid && !out_stall) begin
        got = '{channel_out, voltage_uv, trimmed_sum, kept_count};
        if (expected_readings.size() == 0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("unexpected reading: ch=%0d volt=%0d sum=%0d kept=%0d",
                     got.ch, got.volt, got.sum, got.kept);
          end
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("reading mismatch: expected ch=%0d volt=%0d sum=%0d kept=%0d",
                       want.ch, want.volt, want.sum, want.kept);
              $display("                  actual   ch=%0d volt=%0d sum=%0d kept=%0d",
                       got.ch, got.volt, got.sum, got.kept);
            end
          end
        end
      end
    end
    fail_count   <= errors;
    readings_due <= expected_readings.size();
  end

endmodule

// File: tb/adc_trimmed_mean_voltage_tb.sv
`timescale 1ns / 1ps

module adc_trimmed_mean_voltage_tb;

  localparam int TOP_CODE      = 4095;
  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_ITEMS  = 1350;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [tmv_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tmv_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [11:0]                    sample;
  logic [tmv_pkg::CH_W-1:0]       channel;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [tmv_pkg::CH_W-1:0]       channel_out;
  logic [tmv_pkg::VOLT_W-1:0]     voltage_uv;
  logic [tmv_pkg::SUM_OUT_W-1:0]  trimmed_sum;
  logic [tmv_pkg::KEPT_W-1:0]     kept_count;
  int                             fail_count;
  int                             readings_due;
  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  int                             samples_sent = 0;

  adc_trimmed_mean_voltage dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .channel     (channel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .voltage_uv  (voltage_uv),
    .trimmed_sum (trimmed_sum),
    .kept_count  (kept_count)
  );

  tmv_reading_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .channel      (channel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel_out  (channel_out),
    .voltage_uv   (voltage_uv),
    .trimmed_sum  (trimmed_sum),
    .kept_count   (kept_count),
    .fail_count   (fail_count),
    .readings_due (readings_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one sample transaction, with optional idle cycles ahead of it
  task automatic push_sample(input logic [11:0] code, input logic [tmv_pkg::CH_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= code;
    channel  <= ch;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // hold off until all readings are out and the block has settled
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers on back-to-back cycles
  task automatic write_config(input logic [tmv_pkg::WLEN_W-1:0] wl,
                              input logic [tmv_pkg::FS_W-1:0] fs);
    cfg_write <= 1'b1;
    cfg_index <= tmv_pkg::REG_WINDOW_LEN;
    cfg_data  <= tmv_pkg::CFG_DATA_W'(wl);
    @(posedge clk);
    cfg_index <= tmv_pkg::REG_FULL_SCALE;
    cfg_data  <= fs;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // sample code by content style: spread, cluster, rails or flat
  function automatic logic [11:0] pick_code(int style, int base);
    int v;
    case (style)
      1: begin
        v = base + int'($urandom_range(40)) - 20;
        return 12'((v < 0) ? 0 : ((v > TOP_CODE) ? TOP_CODE : v));
      end
      2: return $urandom_range(1) ? 12'(TOP_CODE) : 12'd0;
      3: return 12'(base);
      default: return 12'($urandom_range(TOP_CODE));
    endcase
  endfunction

  // one random config followed by a few windows and maybe a partial one
  task automatic random_segment();
    int pick;
    int wl;
    int span;
    int windows;
    int style;
    int base;
    logic [tmv_pkg::FS_W-1:0] fs;
    pick = $urandom_range(99);
    if (pick < 70)      wl = $urandom_range(16, 5);
    else if (pick < 80) wl = $urandom_range(4, 1);
    else if (pick < 85) wl = 0;
    else if (pick < 93) wl = $urandom_range(63, 17);
    else if (pick < 97) wl = 64;
    else                wl = $urandom_range(127, 65);
    pick = $urandom_range(99);
    if (pick < 10)      fs = 23'd1;
    else if (pick < 20) fs = 23'd5000000;
    else if (pick < 25) fs = '1;
    else                fs = 23'($urandom_range(5000000, 1));
    quiesce();
    write_config(7'(wl), fs);
    span = (wl == 0) ? 1 : ((wl > 64) ? 64 : wl);
    windows = (span > 20) ? 1 : $urandom_range(4, 1);
    if (span > 1 && $urandom_range(99) < 30) windows++;
    for (int w = 0; w < windows; w++) begin
      pick  = $urandom_range(9);
      style = (pick < 6) ? 0 : ((pick < 8) ? 1 : pick - 6);
      base  = $urandom_range(TOP_CODE);
      // last pass may stop short and leave a partial window behind
      for (int k = 0; k < span; k++) begin
        if (w == windows - 1 && w > 0 && k >= span / 2 && $urandom_range(3) == 0) break;
        push_sample(pick_code(style, base), 2'($urandom_range(3)));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = tmv_pkg::REG_WINDOW_LEN;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample    = '0;
    channel   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 19;
    recv_stall_pct = 57;

    // zero window length behaves as one sample per window
    write_config(7'd0, tmv_pkg::FULL_SCALE_RST);
    push_sample(12'hFFF, 2'd3);
    push_sample(12'h000, 2'd0);
    quiesce();

    // short window, no trimming, full-scale reference at its range top
    write_config(7'd3, 23'd5000000);
    push_sample(12'hFFF, 2'd1);
    push_sample(12'hFFF, 2'd2);
    push_sample(12'hFFF, 2'd1);
    quiesce();

    // equal samples, smallest reference
    write_config(7'd5, 23'd1);
    repeat (5) push_sample(12'h800, 2'd2);
    quiesce();

    // alternating bit patterns, widest reference value
    write_config(7'd4, '1);
    push_sample(12'hAAA, 2'd1);
    push_sample(12'h555, 2'd2);
    push_sample(12'h001, 2'd3);
    push_sample(12'h800, 2'd0);
    quiesce();

    // window shortened after the count already passed the new length
    write_config(7'd20, tmv_pkg::FULL_SCALE_RST);
    for (int k = 0; k < 8; k++) push_sample(12'(TOP_CODE - k * 500), 2'(k));
    quiesce();
    write_config(7'd5, tmv_pkg::FULL_SCALE_RST);
    push_sample(12'h123, 2'd3);

    // random windows over three idling phases
    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      if (samples_sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (samples_sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct  = 57;
        recv_stall_pct = 19;
      end
      random_segment();
    end

    quiesce();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: adc_trimmed_mean_voltage.f
sv/tmv_pkg.sv
sv/tmv_cell.sv
sv/tmv_chain.sv
sv/tmv_muldiv.sv
sv/adc_trimmed_mean_voltage.sv
tb/tmv_reading_checker.sv
tb/adc_trimmed_mean_voltage_tb.sv
